/* hw/rtl/ppm_offset_calibrator_assert.svh */
// assertion macros for the calibrator checker
`ifndef PPM_OFFSET_CALIBRATOR_ASSERT_SVH
`define PPM_OFFSET_CALIBRATOR_ASSERT_SVH

// same-cycle implication
`define POC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("poc assertion failed");

// next-cycle implication
`define POC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("poc assertion failed");

`endif

/* hw/rtl/poc_pkg.sv */
package poc_pkg;

	localparam int TIME_SHIFT = 10;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam int MUL_A_W   = 192;
	localparam int MUL_B_W   = 64;
	localparam int MUL_P_W   = 256;
	localparam int MUL_STEPS = (MUL_A_W / 32) * (MUL_B_W / 32);
	localparam int MUL_IDX_W = $clog2(MUL_STEPS);

	localparam int DIV_N_W = 192;
	localparam int DIV_D_W = 160;
	localparam int DIV_Q_W = 32;
	localparam int DIV_C_W = $clog2(DIV_Q_W);

	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_BYTE  = 2'd1;
	localparam logic [1:0] MODE_END   = 2'd2;

	typedef enum logic [1:0] {K_START, K_BYTE, K_END, K_NOP} kind_t;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_SETTLE = 3'd1;
	localparam logic [2:0] PH_WIN1   = 3'd2;
	localparam logic [2:0] PH_WIN2   = 3'd3;
	localparam logic [2:0] PH_WIN3   = 3'd4;
	localparam logic [2:0] PH_READY  = 3'd5;
	localparam logic [2:0] PH_FAILED = 3'd6;

	localparam logic [3:0] FC_NONE     = 4'd0;
	localparam logic [3:0] FC_START    = 4'd1;
	localparam logic [3:0] FC_TIME     = 4'd2;
	localparam logic [3:0] FC_DROPPED  = 4'd3;
	localparam logic [3:0] FC_ODD      = 4'd4;
	localparam logic [3:0] FC_COUNTER  = 4'd5;
	localparam logic [3:0] FC_OVERFLOW = 4'd6;
	localparam logic [3:0] FC_WINDOW   = 4'd7;
	localparam logic [3:0] FC_SPREAD   = 4'd8;
	localparam logic [3:0] FC_RANGE    = 4'd9;

	localparam logic [2:0] REG_RATE   = 3'd0;
	localparam logic [2:0] REG_SETTLE = 3'd1;
	localparam logic [2:0] REG_WINDOW = 3'd2;
	localparam logic [2:0] REG_SPREAD = 3'd3;
	localparam logic [2:0] REG_CORR   = 3'd4;

	localparam logic [31:0] RATE_RESET   = 32'd2048000;
	localparam logic [39:0] SETTLE_RESET = 40'd1000000000;
	localparam logic [39:0] WINDOW_RESET = 40'd2000000000;
	localparam logic [19:0] SPREAD_RESET = 20'd2048;
	localparam logic [9:0]  CORR_RESET   = 10'd200;

	localparam logic [63:0] NS_PER_S      = 64'd1000000000;
	localparam logic [63:0] Q10_PPM_SCALE = 64'd1024000000;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  cbyte;
		logic [62:0] ts;
		logic        dropped;
	} item_t;

	typedef struct packed {
		logic [31:0] rate;
		logic [39:0] settle;
		logic [39:0] window;
		logic [19:0] spread;
		logic [9:0]  corr_max;
	} cfg_t;

	typedef struct packed {
		logic               start;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic               done;
		logic [MUL_P_W-1:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] num;
		logic [DIV_D_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic               sat;
		logic [DIV_Q_W-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic        corr_valid;
		logic [10:0] corr;
		logic [3:0]  fail;
		logic [1:0]  wcount;
		logic [31:0] last_ppm;
	} res_t;

	// q10 ppm to integer ppm, half away from zero
	function automatic logic signed [22:0] round_q10(input logic signed [31:0] q);
		logic [31:0] mag;
		logic [32:0] sum;
		logic [22:0] r;
		mag = q[31] ? 32'(-q) : 32'(q);
		sum = {1'b0, mag} + 33'd512;
		r = sum[32:10];
		return q[31] ? -$signed(r) : $signed(r);
	endfunction

endpackage

/* hw/rtl/poc_front.sv */
module poc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  logic [1:0]     mode,
	input  logic [7:0]     counter_byte,
	input  logic [62:0]    timestamp_ns,
	input  logic           dropped_data,
	output logic           q_valid,
	output poc_pkg::item_t q_item,
	input  logic           q_full
);
	import poc_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	kind_t kind;
	logic  accept;

	always_comb begin
		unique case (mode)
			MODE_START: kind = K_START;
			MODE_BYTE:  kind = K_BYTE;
			MODE_END:   kind = K_END;
			default:    kind = K_NOP;
		endcase
	end

	assign full    = valid_s1 && q_full;
	assign accept  = push && !full;
	assign q_valid = valid_s1;
	assign q_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (valid_s1 && !q_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{kind: kind, cbyte: counter_byte, ts: timestamp_ns,
				dropped: dropped_data};
		end
	end

endmodule

/* hw/rtl/poc_fifo.sv */
module poc_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	input  poc_pkg::item_t wr_item,
	output logic           full,
	input  logic           rd_pop,
	output poc_pkg::item_t rd_item,
	output logic           empty
);
	import poc_pkg::*;

	item_t             mem [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   count_q;
	logic              wr_en;
	logic              rd_en;

	assign full    = count_q == (QPTR_W+1)'(QDEPTH);
	assign empty   = count_q == '0;
	assign wr_en   = wr_valid && !full;
	assign rd_en   = rd_pop && !empty;
	assign rd_item = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd_en) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/poc_mul.sv */
module poc_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  poc_pkg::mul_req_t req,
	output poc_pkg::mul_rsp_t rsp
);
	import poc_pkg::*;

	logic [MUL_A_W-1:0]   a_q;
	logic [MUL_B_W-1:0]   b_q;
	logic [MUL_P_W-1:0]   acc_q;
	logic [MUL_IDX_W-1:0] idx_q;
	logic                 busy_q;
	logic                 done_q;

	logic [MUL_IDX_W-2:0] wi;
	logic                 wj;
	logic [31:0]          a_word;
	logic [31:0]          b_word;
	logic [63:0]          pp;
	logic [MUL_IDX_W-2:0] wsum;
	logic [MUL_P_W-1:0]   pp_sh;

	assign wi     = idx_q[MUL_IDX_W-1:1];
	assign wj     = idx_q[0];
	assign a_word = a_q[32*wi +: 32];
	assign b_word = b_q[32*wj +: 32];
	assign pp     = a_word * b_word;
	assign wsum   = wi + (MUL_IDX_W-1)'(wj);
	assign pp_sh  = MUL_P_W'(pp) << {wsum, 5'b0};

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
			acc_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				a_q    <= req.a;
				b_q    <= req.b;
				acc_q  <= '0;
				idx_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				acc_q <= acc_q + pp_sh;
				idx_q <= idx_q + 1'b1;
				if (idx_q == MUL_IDX_W'(MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

/* hw/rtl/poc_div.sv */
module poc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  poc_pkg::div_req_t req,
	output poc_pkg::div_rsp_t rsp
);
	import poc_pkg::*;

	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] den_q;
	logic [DIV_Q_W-1:0] low_q;
	logic [DIV_Q_W-1:0] quo_q;
	logic [DIV_C_W-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;
	logic               sat_q;

	logic [DIV_D_W:0] r2;
	logic [DIV_D_W:0] r2_sub;
	logic             qbit;

	assign r2     = {rem_q, low_q[DIV_Q_W-1]};
	assign r2_sub = r2 - {1'b0, den_q};
	assign qbit   = r2 >= {1'b0, den_q};

	assign rsp.done = done_q;
	assign rsp.sat  = sat_q;
	assign rsp.quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sat_q  <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			low_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				den_q <= req.den;
				rem_q <= req.num[DIV_N_W-1:DIV_Q_W];
				low_q <= req.num[DIV_Q_W-1:0];
				quo_q <= '0;
				cnt_q <= '0;
				// quotient would not fit in the result width
				if (req.num[DIV_N_W-1:DIV_Q_W] >= req.den) begin
					sat_q  <= 1'b1;
					done_q <= 1'b1;
				end else begin
					sat_q  <= 1'b0;
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				rem_q <= qbit ? r2_sub[DIV_D_W-1:0] : r2[DIV_D_W-1:0];
				low_q <= {low_q[DIV_Q_W-2:0], 1'b0};
				quo_q <= {quo_q[DIV_Q_W-2:0], qbit};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_C_W'(DIV_Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

/* hw/rtl/poc_back.sv */
module poc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  poc_pkg::cfg_t     cfg,
	input  logic              q_empty,
	input  poc_pkg::item_t    q_item,
	output logic              q_pop,
	output poc_pkg::mul_req_t mreq,
	input  poc_pkg::mul_rsp_t mrsp,
	output poc_pkg::div_req_t dreq,
	input  poc_pkg::div_rsp_t drsp,
	input  logic              pop,
	output logic              res_valid,
	output poc_pkg::res_t     res
);
	import poc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_EB, S_TT, S_TS, S_WIN, S_D1, S_D2, S_A1, S_A2,
		S_NK, S_QD, S_PK, S_DIV, S_FIN, S_EMIT
	} state_t;

	state_t      state_q;
	logic [2:0]  phase_q;
	logic [7:0]  prev_q;
	logic        prev_valid_q;
	logic        settle_seen_q;
	logic [1:0]  breaks_q;
	logic [31:0] byte_count_q;
	logic [62:0] phase_start_q;
	logic [62:0] last_time_q;
	logic [63:0] win_samples_q;
	logic [31:0] obs_q;
	logic [63:0] sum_t_q;
	logic [63:0] sum_s_q;
	logic [63:0] sum_tt_q;
	logic [63:0] sum_ts_q;
	logic [31:0] ppm_store_q [3];
	logic [10:0] held_corr_q;
	logic [3:0]  held_fail_q;
	logic [1:0]  win_done_q;

	logic [62:0]  ts_q;
	logic         drop_q;
	logic [31:0]  cnt_q;
	logic [1:0]   brk_q;
	logic [63:0]  t_q;
	logic [127:0] tmp_q;
	logic [127:0] den_q;
	logic [159:0] num_q;
	logic [159:0] qd_q;
	logic         neg_q;
	logic         res_valid_q;
	res_t         res_q;
	mul_req_t     mreq_q;
	div_req_t     dreq_q;

	logic [63:0]  ts_dif;
	logic [63:0]  win_dif;
	logic [63:0]  tval;
	logic [63:0]  half_cnt;
	logic [63:0]  ws_new;
	logic         out_free;
	logic [127:0] prod_lo;
	logic         a_neg;
	logic [127:0] a_abs;
	logic [159:0] qdv;
	logic [159:0] p_val;
	logic         p_neg;
	logic [31:0]  qmag;
	logic [31:0]  ppm_new;
	logic         st_we;

	logic signed [31:0] s0, s1, s2, lo01, hi01, lo, hi, med, sel;
	logic signed [22:0] r0, r1, corr;
	logic [22:0]        cmag;
	logic [32:0]        spread;
	logic [33:0]        med_sum;
	logic               fin_meas;

	assign q_pop     = (state_q == S_IDLE) && !q_empty;
	assign mreq      = mreq_q;
	assign dreq      = dreq_q;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign out_free  = !res_valid_q || pop;

	assign ts_dif   = 64'(ts_q) - 64'(phase_start_q);
	assign win_dif  = 64'(last_time_q) - 64'(phase_start_q);
	assign tval     = ts_dif >> TIME_SHIFT;
	assign half_cnt = {33'b0, cnt_q[31:1]};
	assign ws_new   = win_samples_q + half_cnt;

	assign prod_lo = mrsp.prod[127:0];
	assign a_neg   = tmp_q < prod_lo;
	assign a_abs   = a_neg ? prod_lo - tmp_q : tmp_q - prod_lo;
	assign qdv     = mrsp.prod[159:0];

	always_comb begin
		if (neg_q) begin
			p_val = num_q + qdv;
			p_neg = 1'b1;
		end else if (num_q >= qdv) begin
			p_val = num_q - qdv;
			p_neg = 1'b0;
		end else begin
			p_val = qdv - num_q;
			p_neg = 1'b1;
		end
	end

	assign qmag = drsp.sat ? '1 : drsp.quo;

	always_comb begin
		if (neg_q) begin
			ppm_new = -((qmag > 32'h8000_0000) ? 32'h8000_0000 : qmag);
		end else begin
			ppm_new = (qmag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : qmag;
		end
	end

	assign st_we = (state_q == S_DIV) && drsp.done;

	// window selection and limits
	assign s0      = ppm_store_q[0];
	assign s1      = ppm_store_q[1];
	assign s2      = ppm_store_q[2];
	assign r0      = round_q10(s0);
	assign r1      = round_q10(s1);
	assign lo01    = (s0 < s1) ? s0 : s1;
	assign hi01    = (s0 < s1) ? s1 : s0;
	assign lo      = (win_done_q == 2'd3 && s2 < lo01) ? s2 : lo01;
	assign hi      = (win_done_q == 2'd3 && s2 > hi01) ? s2 : hi01;
	assign spread  = {hi[31], hi} - {lo[31], lo};
	assign med_sum = {{2{s0[31]}}, s0} + {{2{s1[31]}}, s1} + {{2{s2[31]}}, s2}
		- {{2{lo[31]}}, lo} - {{2{hi[31]}}, hi};
	assign med      = med_sum[31:0];
	assign sel      = (win_done_q == 2'd3) ? med : s0;
	assign corr     = round_q10(sel);
	assign cmag     = corr[22] ? 23'(-corr) : 23'(corr);
	assign fin_meas = (win_done_q == 2'd2 && r0 == r1) || win_done_q == 2'd3;

	always_ff @(posedge clk) begin
		if (st_we) begin
			ppm_store_q[win_done_q] <= ppm_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			phase_q       <= PH_IDLE;
			prev_q        <= '0;
			prev_valid_q  <= 1'b0;
			settle_seen_q <= 1'b0;
			breaks_q      <= '0;
			byte_count_q  <= '0;
			phase_start_q <= '0;
			last_time_q   <= '0;
			win_samples_q <= '0;
			obs_q         <= '0;
			sum_t_q       <= '0;
			sum_s_q       <= '0;
			sum_tt_q      <= '0;
			sum_ts_q      <= '0;
			held_corr_q   <= '0;
			held_fail_q   <= FC_NONE;
			win_done_q    <= '0;
			ts_q          <= '0;
			drop_q        <= 1'b0;
			cnt_q         <= '0;
			brk_q         <= '0;
			t_q           <= '0;
			tmp_q         <= '0;
			den_q         <= '0;
			num_q         <= '0;
			qd_q          <= '0;
			neg_q         <= 1'b0;
			res_valid_q   <= 1'b0;
			res_q         <= '0;
			mreq_q        <= '0;
			dreq_q        <= '0;
		end else begin
			mreq_q.start <= 1'b0;
			dreq_q.start <= 1'b0;
			if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						state_q <= S_EMIT;
						unique case (q_item.kind)
							K_START: begin
								win_done_q    <= '0;
								held_corr_q   <= '0;
								prev_valid_q  <= 1'b0;
								settle_seen_q <= 1'b0;
								win_samples_q <= '0;
								byte_count_q  <= '0;
								breaks_q      <= '0;
								if (cfg.rate == '0 || q_item.ts == '0) begin
									phase_q     <= PH_FAILED;
									held_fail_q <= FC_START;
								end else begin
									held_fail_q   <= FC_NONE;
									phase_q       <= PH_SETTLE;
									phase_start_q <= q_item.ts;
									last_time_q   <= q_item.ts;
								end
							end
							K_BYTE: begin
								if (byte_count_q != '1) begin
									byte_count_q <= byte_count_q + 1'b1;
								end
								if (phase_q >= PH_SETTLE && phase_q <= PH_WIN3) begin
									if (prev_valid_q && q_item.cbyte != prev_q + 8'd1
										&& breaks_q != 2'd3) begin
										breaks_q <= breaks_q + 1'b1;
									end
									prev_q       <= q_item.cbyte;
									prev_valid_q <= 1'b1;
								end
							end
							K_END: begin
								ts_q         <= q_item.ts;
								drop_q       <= q_item.dropped;
								cnt_q        <= byte_count_q;
								brk_q        <= breaks_q;
								byte_count_q <= '0;
								breaks_q     <= '0;
								state_q      <= S_EB;
							end
							default: ;
						endcase
					end
				end
				S_EB: begin
					state_q <= S_EMIT;
					if (phase_q == PH_READY || phase_q == PH_FAILED) begin
						// buffer discarded
					end else if (ts_q <= last_time_q) begin
						phase_q     <= PH_FAILED;
						held_corr_q <= '0;
						held_fail_q <= FC_TIME;
					end else begin
						last_time_q <= ts_q;
						if (drop_q) begin
							phase_q     <= PH_FAILED;
							held_corr_q <= '0;
							held_fail_q <= FC_DROPPED;
						end else if (cnt_q == '0 || cnt_q[0]) begin
							phase_q     <= PH_FAILED;
							held_corr_q <= '0;
							held_fail_q <= FC_ODD;
						end else if (phase_q == PH_SETTLE) begin
							if ((settle_seen_q && brk_q != '0) || brk_q > 2'd1) begin
								phase_q     <= PH_FAILED;
								held_corr_q <= '0;
								held_fail_q <= FC_COUNTER;
							end else begin
								settle_seen_q <= 1'b1;
								if (ts_dif >= 64'(cfg.settle)) begin
									phase_q       <= PH_WIN1;
									phase_start_q <= ts_q;
									win_samples_q <= '0;
									obs_q         <= 32'd1;
									sum_t_q       <= '0;
									sum_s_q       <= '0;
									sum_tt_q      <= '0;
									sum_ts_q      <= '0;
								end
							end
						end else if (phase_q == PH_IDLE) begin
							// nothing to measure
						end else if (brk_q != '0) begin
							phase_q     <= PH_FAILED;
							held_corr_q <= '0;
							held_fail_q <= FC_COUNTER;
						end else if (half_cnt > ~win_samples_q) begin
							phase_q     <= PH_FAILED;
							held_corr_q <= '0;
							held_fail_q <= FC_OVERFLOW;
						end else begin
							win_samples_q <= ws_new;
							t_q           <= tval;
							if (obs_q != '1) begin
								obs_q <= obs_q + 1'b1;
							end
							sum_t_q      <= sum_t_q + tval;
							sum_s_q      <= sum_s_q + ws_new;
							mreq_q.start <= 1'b1;
							mreq_q.a     <= MUL_A_W'(tval);
							mreq_q.b     <= tval;
							state_q      <= S_TT;
						end
					end
				end
				S_TT: begin
					if (mrsp.done) begin
						sum_tt_q     <= sum_tt_q + mrsp.prod[63:0];
						mreq_q.start <= 1'b1;
						mreq_q.a     <= MUL_A_W'(t_q);
						mreq_q.b     <= win_samples_q;
						state_q      <= S_TS;
					end
				end
				S_TS: begin
					if (mrsp.done) begin
						sum_ts_q <= sum_ts_q + mrsp.prod[63:0];
						state_q  <= S_WIN;
					end
				end
				S_WIN: begin
					if (win_dif >= 64'(cfg.window)) begin
						if (obs_q < 32'd2 || cfg.rate == '0) begin
							phase_q     <= PH_FAILED;
							held_corr_q <= '0;
							held_fail_q <= FC_WINDOW;
							state_q     <= S_EMIT;
						end else begin
							mreq_q.start <= 1'b1;
							mreq_q.a     <= MUL_A_W'(sum_tt_q);
							mreq_q.b     <= 64'(obs_q);
							state_q      <= S_D1;
						end
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_D1: begin
					if (mrsp.done) begin
						tmp_q        <= prod_lo;
						mreq_q.start <= 1'b1;
						mreq_q.a     <= MUL_A_W'(sum_t_q);
						mreq_q.b     <= sum_t_q;
						state_q      <= S_D2;
					end
				end
				S_D2: begin
					if (mrsp.done) begin
						if (tmp_q <= prod_lo) begin
							phase_q     <= PH_FAILED;
							held_corr_q <= '0;
							held_fail_q <= FC_WINDOW;
							state_q     <= S_EMIT;
						end else begin
							den_q        <= tmp_q - prod_lo;
							mreq_q.start <= 1'b1;
							mreq_q.a     <= MUL_A_W'(sum_ts_q);
							mreq_q.b     <= 64'(obs_q);
							state_q      <= S_A1;
						end
					end
				end
				S_A1: begin
					if (mrsp.done) begin
						tmp_q        <= prod_lo;
						mreq_q.start <= 1'b1;
						mreq_q.a     <= MUL_A_W'(sum_t_q);
						mreq_q.b     <= sum_s_q;
						state_q      <= S_A2;
					end
				end
				S_A2: begin
					if (mrsp.done) begin
						neg_q        <= a_neg;
						mreq_q.start <= 1'b1;
						mreq_q.a     <= MUL_A_W'(a_abs);
						mreq_q.b     <= NS_PER_S;
						state_q      <= S_NK;
					end
				end
				S_NK: begin
					if (mrsp.done) begin
						num_q        <= mrsp.prod[159:0];
						mreq_q.start <= 1'b1;
						mreq_q.a     <= MUL_A_W'(den_q);
						mreq_q.b     <= 64'(cfg.rate) << TIME_SHIFT;
						state_q      <= S_QD;
					end
				end
				S_QD: begin
					if (mrsp.done) begin
						qd_q         <= qdv;
						neg_q        <= p_neg;
						mreq_q.start <= 1'b1;
						mreq_q.a     <= MUL_A_W'(p_val);
						mreq_q.b     <= Q10_PPM_SCALE;
						state_q      <= S_PK;
					end
				end
				S_PK: begin
					if (mrsp.done) begin
						// round half away: (2p + q) / 2q
						dreq_q.start <= 1'b1;
						dreq_q.num   <= {mrsp.prod[DIV_N_W-2:0], 1'b0} + DIV_N_W'(qd_q);
						dreq_q.den   <= {qd_q[DIV_D_W-2:0], 1'b0};
						state_q      <= S_DIV;
					end
				end
				S_DIV: begin
					if (drsp.done) begin
						win_done_q <= win_done_q + 1'b1;
						state_q    <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_EMIT;
					if (fin_meas) begin
						if (spread > 33'(cfg.spread)) begin
							phase_q     <= PH_FAILED;
							held_corr_q <= '0;
							held_fail_q <= FC_SPREAD;
						end else if (cmag > 23'(cfg.corr_max)) begin
							phase_q     <= PH_FAILED;
							held_corr_q <= '0;
							held_fail_q <= FC_RANGE;
						end else begin
							held_corr_q <= corr[10:0];
							phase_q     <= PH_READY;
						end
					end else begin
						phase_q       <= (win_done_q == 2'd1) ? PH_WIN2 : PH_WIN3;
						phase_start_q <= ts_q;
						win_samples_q <= '0;
						obs_q         <= 32'd1;
						sum_t_q       <= '0;
						sum_s_q       <= '0;
						sum_tt_q      <= '0;
						sum_ts_q      <= '0;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						res_valid_q      <= 1'b1;
						res_q.phase      <= phase_q;
						res_q.corr_valid <= phase_q == PH_READY;
						res_q.corr       <= (phase_q == PH_READY) ? held_corr_q : '0;
						res_q.fail       <= (phase_q == PH_FAILED) ? held_fail_q : FC_NONE;
						res_q.wcount     <= win_done_q;
						res_q.last_ppm   <= (win_done_q != '0)
							? ppm_store_q[win_done_q - 2'd1] : '0;
						state_q          <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/ppm_offset_calibrator.sv */
// sample-clock ppm calibrator fed by a test-counter byte stream
// input channel: push/full queue; mode 0 starts a run, mode 1 carries a
// counter byte, mode 2 ends a buffer with its timestamp and dropped flag
// result channel: empty/pop queue; one result item per input item, giving
// phase, correction, failure code, window count and last window ppm
// configuration: apb write/read, 64-bit data, register i at byte 8*i
// start and byte items pass the input stage, the item queue, then the back end's
// idle and emit states
// a measuring end of buffer adds two multiplies
// a window end adds seven more multiplies and a divide, run on the shared
// 32x32 multiplier and the radix-2 divider
// the back end handles one item at a time, popping the queue only while idle
// reset: phase idle, all sums and counters zero, registers at defaults
// a stalled result holds its outputs; the item queue keeps filling and
// full rises once the queue and the input stage are occupied
module ppm_offset_calibrator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         mode,
	input  logic [7:0]         counter_byte,
	input  logic [62:0]        timestamp_ns,
	input  logic               dropped_data,
	output logic               empty,
	input  logic               pop,
	output logic [2:0]         phase,
	output logic               correction_valid,
	output logic signed [10:0] correction_ppm,
	output logic [3:0]         failure_code,
	output logic [1:0]         window_count,
	output logic signed [31:0] last_window_ppm_q10
);
	import poc_pkg::*;

	cfg_t     cfg_q;
	logic     cfg_wr;
	logic [2:0] reg_idx;
	logic     f_valid;
	item_t    f_item;
	logic     q_full;
	item_t    q_item;
	logic     q_empty;
	logic     q_pop;
	mul_req_t mreq;
	mul_rsp_t mrsp;
	div_req_t dreq;
	div_rsp_t drsp;
	logic     res_valid;
	res_t     res;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate     <= RATE_RESET;
			cfg_q.settle   <= SETTLE_RESET;
			cfg_q.window   <= WINDOW_RESET;
			cfg_q.spread   <= SPREAD_RESET;
			cfg_q.corr_max <= CORR_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_RATE:   cfg_q.rate     <= pwdata[31:0];
				REG_SETTLE: cfg_q.settle   <= pwdata[39:0];
				REG_WINDOW: cfg_q.window   <= pwdata[39:0];
				REG_SPREAD: cfg_q.spread   <= pwdata[19:0];
				REG_CORR:   cfg_q.corr_max <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RATE:   prdata = 64'(cfg_q.rate);
			REG_SETTLE: prdata = 64'(cfg_q.settle);
			REG_WINDOW: prdata = 64'(cfg_q.window);
			REG_SPREAD: prdata = 64'(cfg_q.spread);
			REG_CORR:   prdata = 64'(cfg_q.corr_max);
			default:    prdata = '0;
		endcase
	end

	poc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.mode         (mode),
		.counter_byte (counter_byte),
		.timestamp_ns (timestamp_ns),
		.dropped_data (dropped_data),
		.q_valid      (f_valid),
		.q_item       (f_item),
		.q_full       (q_full)
	);

	poc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_item  (f_item),
		.full     (q_full),
		.rd_pop   (q_pop),
		.rd_item  (q_item),
		.empty    (q_empty)
	);

	poc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	poc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	poc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.mreq      (mreq),
		.mrsp      (mrsp),
		.dreq      (dreq),
		.drsp      (drsp),
		.pop       (pop),
		.res_valid (res_valid),
		.res       (res)
	);

	assign empty               = !res_valid;
	assign phase               = res.phase;
	assign correction_valid    = res.corr_valid;
	assign correction_ppm      = $signed(res.corr);
	assign failure_code        = res.fail;
	assign window_count        = res.wcount;
	assign last_window_ppm_q10 = $signed(res.last_ppm);

endmodule

/* hw/rtl/poc_checker.sv */
`include "ppm_offset_calibrator_assert.svh"

module poc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic [2:0]         phase,
	input logic               correction_valid,
	input logic signed [10:0] correction_ppm,
	input logic [3:0]         failure_code,
	input logic [1:0]         window_count,
	input logic signed [31:0] last_window_ppm_q10
);
	import poc_pkg::*;

	`POC_ASSERT_NXT(a_res_hold, clk, arst_n, !empty && !pop,
		!empty && $stable(phase) && $stable(last_window_ppm_q10))
	`POC_ASSERT_IMP(a_cv_ready, clk, arst_n, !empty,
		(correction_valid == (phase == PH_READY)))
	`POC_ASSERT_IMP(a_fail_only, clk, arst_n, !empty && (phase != PH_FAILED),
		(failure_code == FC_NONE))
	`POC_ASSERT_IMP(a_ppm_nowin, clk, arst_n, !empty && (window_count == 2'd0),
		(last_window_ppm_q10 == 32'sd0))
	`POC_ASSERT_IMP(a_corr_zero, clk, arst_n, !empty && (phase != PH_READY),
		(correction_ppm == 11'sd0))

endmodule

bind ppm_offset_calibrator poc_checker u_poc_checker (.*);
